// ===== src/opfp_pkg.sv =====
// ----------------------------------------------------------------------------
// opfp_pkg
// Shared types, constants and TOC decode for the Opus packet framing parser.
// ----------------------------------------------------------------------------
package opfp_pkg;

  // Parameter defaults
  localparam int DEF_MAX_FRAMES       = 48;
  localparam int DEF_MAX_FRAME_BYTES  = 1275;
  localparam int DEF_MAX_DURATION     = 5760;
  localparam int DEF_MAX_PACKET_BYTES = 65535;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // TOC frame count codes
  localparam logic [1:0] CODE_ONE   = 2'd0;
  localparam logic [1:0] CODE_EQUAL = 2'd1;
  localparam logic [1:0] CODE_TWO   = 2'd2;
  localparam logic [1:0] CODE_ARB   = 2'd3;

  // Byte values with special meaning
  localparam logic [7:0] SIZE_ESC = 8'd252;  // two-byte frame size from here up
  localparam logic [7:0] PAD_CONT = 8'd255;  // padding run continues
  localparam logic [7:0] PAD_STEP = 8'd254;  // padding added by a continue byte

  // Divider widths
  localparam int DIV_NW = 16;
  localparam int DIV_DW = 6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  bw;
    logic [11:0] fs;
  } toc_info_t;

  // Controller to datapath
  typedef struct packed {
    logic take_toc;
    logic take_count;
    logic take_pad;
    logic take_low;
    logic take_size;
    logic size_wide;
    logic div_start;
    logic div_load;
    logic emit_start;
    logic emit_step;
    logic out_fail;
    logic out_empty;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       plen_zero;
    logic       plen_big;
    logic       plen_one;
    logic       plen_even;
    logic [1:0] toc_code;
    logic       rem_zero;
    logic       remd_zero;
    logic       cnt_bad;
    logic       byte_pad;
    logic       byte_ff;
    logic       byte_esc;
    logic       pad_fail;
    logic       cb_vbr;
    logic       cb_le1;
    logic       fl_vbr;
    logic       cnt_le1;
    logic       rpad_zero;
    logic       size_fail_n;
    logic       size_fail_w;
    logic       size_done;
    logic       lsz_big;
    logic       div_done;
    logic       div_rem_nz;
    logic       out_free;
    logic       emit_last;
  } sts_t;

  // TOC config field to mode, bandwidth and samples per frame
  function automatic toc_info_t toc_decode(input logic [7:0] toc);
    logic [4:0] cfg;
    toc_info_t  ti;
    cfg = toc[7:3];
    if (cfg < 5'd12) begin
      ti.mode = 2'd0;
      ti.bw   = {1'b0, cfg[3:2]};
      case (cfg[1:0])
        2'd0:    ti.fs = 12'd480;
        2'd1:    ti.fs = 12'd960;
        2'd2:    ti.fs = 12'd1920;
        default: ti.fs = 12'd2880;
      endcase
    end else if (cfg < 5'd16) begin
      ti.mode = 2'd1;
      ti.bw   = cfg[1] ? 3'd4 : 3'd3;
      ti.fs   = cfg[0] ? 12'd960 : 12'd480;
    end else begin
      ti.mode = 2'd2;
      case (cfg[3:2])
        2'd0:    ti.bw = 3'd0;
        2'd1:    ti.bw = 3'd2;
        2'd2:    ti.bw = 3'd3;
        default: ti.bw = 3'd4;
      endcase
      case (cfg[1:0])
        2'd0:    ti.fs = 12'd120;
        2'd1:    ti.fs = 12'd240;
        2'd2:    ti.fs = 12'd480;
        default: ti.fs = 12'd960;
      endcase
    end
    return ti;
  endfunction

endpackage

// ===== src/opfp_div.sv =====
// ----------------------------------------------------------------------------
// opfp_div
// Restoring divider, one quotient bit per cycle, for constant frame sizes.
// ----------------------------------------------------------------------------
module opfp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [opfp_pkg::DIV_NW-1:0] num,
  input  logic [opfp_pkg::DIV_DW-1:0] den,
  output logic                      done,
  output logic [opfp_pkg::DIV_NW-1:0] quo,
  output logic [opfp_pkg::DIV_DW-1:0] rmd
);
  import opfp_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic            running;
  logic [CW-1:0]   step;
  logic [DIV_DW:0] part;
  logic [DIV_DW-1:0] dreg;
  logic [DIV_DW:0] trial;
  logic            fits;

  // shift in next dividend bit, subtract if it fits
  assign trial = {part[DIV_DW-1:0], quo[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dreg};
  assign rmd   = part[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + CW'(1);
        if (step == CW'(DIV_NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      quo  <= num;
      dreg <= den;
    end else if (running) begin
      part <= fits ? (trial - {1'b0, dreg}) : trial;
      quo  <= {quo[DIV_NW-2:0], fits};
    end
  end

endmodule

// ===== src/opfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// opfp_ctrl
// Header parse sequencer: walks TOC, count, padding and size bytes, then
// drives division, size check and descriptor emission, or an empty or error result.
// ----------------------------------------------------------------------------
module opfp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           first_byte,
  output logic           in_stall,
  input  opfp_pkg::sts_t sts,
  output opfp_pkg::cmd_t cmd
);
  import opfp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_COUNT = 4'd1;
  localparam logic [3:0] S_PAD   = 4'd2;
  localparam logic [3:0] S_SIZE1 = 4'd3;
  localparam logic [3:0] S_SIZE2 = 4'd4;
  localparam logic [3:0] S_DIVST = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_FAIL  = 4'd10;
  localparam logic [3:0] S_EMPTY = 4'd11;

  logic [3:0] state, state_next;
  logic       byte_st;
  logic       acc;
  logic [3:0] ap_cnt_next;
  logic [3:0] ap_pad_next;
  logic [3:0] sz_n_next;
  logic [3:0] sz_w_next;

  // bytes are taken only while parsing or idle
  assign byte_st  = (state == S_IDLE) || (state == S_COUNT) || (state == S_PAD) ||
                    (state == S_SIZE1) || (state == S_SIZE2);
  assign in_stall = !byte_st;
  assign acc      = in_valid && byte_st;

  // where to go once padding is settled: straight from the count byte
  assign ap_cnt_next = sts.cb_vbr ? (sts.cb_le1 ? S_CHK : (sts.remd_zero ? S_FAIL : S_SIZE1))
                                  : S_DIVST;
  // or from the closing padding byte
  assign ap_pad_next = sts.fl_vbr ? (sts.cnt_le1 ? S_CHK : (sts.rpad_zero ? S_FAIL : S_SIZE1))
                                  : S_DIVST;
  // where to go after a one-byte or a two-byte frame size is taken
  assign sz_n_next = sts.size_fail_n ? S_FAIL :
                     sts.size_done   ? S_CHK  :
                     sts.remd_zero   ? S_FAIL : S_SIZE1;
  assign sz_w_next = sts.size_fail_w ? S_FAIL :
                     sts.size_done   ? S_CHK  :
                     sts.remd_zero   ? S_FAIL : S_SIZE1;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE, S_COUNT, S_PAD, S_SIZE1, S_SIZE2: begin
        if (acc && first_byte) begin
          cmd.take_toc = 1'b1;
          if (sts.plen_zero) begin
            state_next = S_EMPTY;
          end else if (sts.plen_big) begin
            state_next = S_FAIL;
          end else begin
            case (sts.toc_code)
              CODE_ONE:   state_next = S_CHK;
              CODE_EQUAL: state_next = sts.plen_even ? S_FAIL : S_CHK;
              CODE_TWO:   state_next = sts.plen_one ? S_FAIL : S_SIZE1;
              CODE_ARB:   state_next = sts.plen_one ? S_FAIL : S_COUNT;
              default:    state_next = S_FAIL;
            endcase
          end
        end else if (acc && state != S_IDLE) begin
          if (sts.rem_zero) begin
            state_next = S_FAIL;
          end else begin
            case (state)
              S_COUNT: begin
                cmd.take_count = 1'b1;
                if (sts.cnt_bad)       state_next = S_FAIL;
                else if (sts.byte_pad) state_next = sts.remd_zero ? S_FAIL : S_PAD;
                else                   state_next = ap_cnt_next;
              end
              S_PAD: begin
                cmd.take_pad = 1'b1;
                if (sts.pad_fail)     state_next = S_FAIL;
                else if (sts.byte_ff) state_next = sts.remd_zero ? S_FAIL : S_PAD;
                else                  state_next = ap_pad_next;
              end
              S_SIZE1: begin
                if (!sts.byte_esc) begin
                  cmd.take_size = 1'b1;
                  state_next    = sz_n_next;
                end else begin
                  cmd.take_low = 1'b1;
                  state_next   = sts.remd_zero ? S_FAIL : S_SIZE2;
                end
              end
              default: begin
                cmd.take_size = 1'b1;
                cmd.size_wide = 1'b1;
                state_next    = sz_w_next;
              end
            endcase
          end
        end
      end
      S_DIVST: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_load = 1'b1;
          state_next   = sts.div_rem_nz ? S_FAIL : S_CHK;
        end
      end
      S_CHK: begin
        if (sts.lsz_big) begin
          state_next = S_FAIL;
        end else begin
          cmd.emit_start = 1'b1;
          state_next     = S_RD;
        end
      end
      S_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          state_next    = sts.emit_last ? S_IDLE : S_RD;
        end
      end
      S_FAIL: begin
        if (sts.out_free) begin
          cmd.out_fail = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_empty = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/opfp_dp.sv =====
// ----------------------------------------------------------------------------
// opfp_dp
// Header registers, frame size memory, divider and the output register.
// ----------------------------------------------------------------------------
module opfp_dp #(
  parameter int MAX_FRAMES       = opfp_pkg::DEF_MAX_FRAMES,
  parameter int MAX_FRAME_BYTES  = opfp_pkg::DEF_MAX_FRAME_BYTES,
  parameter int MAX_DURATION     = opfp_pkg::DEF_MAX_DURATION,
  parameter int MAX_PACKET_BYTES = opfp_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     data_byte,
  input  logic [15:0]    packet_length,
  input  opfp_pkg::cmd_t cmd,
  output opfp_pkg::sts_t sts,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [1:0]     status,
  output logic [1:0]     mode,
  output logic [2:0]     bandwidth,
  output logic           stereo,
  output logic [11:0]    samples_per_frame,
  output logic [1:0]     frame_code,
  output logic [5:0]     frame_count,
  output logic [5:0]     frame_index,
  output logic [10:0]    frame_size,
  output logic [15:0]    frame_offset,
  output logic [15:0]    padding_bytes,
  output logic           last
);
  import opfp_pkg::*;

  localparam int IW = (MAX_FRAMES > 2) ? $clog2(MAX_FRAMES) : 1;

  // header state
  logic [7:0]  toc;
  logic [15:0] rem;
  logic [15:0] hdr;
  logic [5:0]  cnt;
  logic [1:0]  flags;   // bit 0 padding, bit 1 variable sizes
  logic [15:0] pad;
  logic [7:0]  low;
  logic [5:0]  sidx;
  logic [15:0] last_acc;
  logic [15:0] lsz;
  logic        cbr;
  logic [5:0]  idx;
  logic [15:0] off;

  logic [10:0] mem [MAX_FRAMES];
  logic [10:0] mem_q;

  toc_info_t   ti;
  logic [15:0] plen_m1;
  logic [15:0] remd;
  logic [5:0]  cb;
  logic [17:0] dur;
  logic [7:0]  padd;
  logic [16:0] acc17;
  logic [15:0] r_pad;
  logic [10:0] sz_w;
  logic [16:0] szn_n;
  logic [16:0] szn_w;
  logic [10:0] sz;
  logic [16:0] szn;
  logic [15:0] new_last;
  logic [10:0] esz;
  logic        emit_last;
  logic        out_free;

  logic              div_done;
  logic [DIV_NW-1:0] div_q;
  logic [DIV_DW-1:0] div_r;

  opfp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (rem),
    .den   (cnt),
    .done  (div_done),
    .quo   (div_q),
    .rmd   (div_r)
  );

  // byte arithmetic
  assign ti       = toc_decode(toc);
  assign plen_m1  = packet_length - 16'd1;
  assign remd     = rem - 16'd1;
  assign cb       = data_byte[5:0];
  assign dur      = 18'(ti.fs) * 18'(cb);
  assign padd     = (data_byte == PAD_CONT) ? PAD_STEP : data_byte;
  assign acc17    = {1'b0, pad} + 17'(padd);
  assign r_pad    = remd - acc17[15:0];
  assign sz_w     = {1'b0, data_byte, 2'b00} + 11'(low);
  assign szn_n    = 17'(data_byte) + 17'd1;
  assign szn_w    = 17'(sz_w) + 17'd2;
  assign sz       = cmd.size_wide ? sz_w : 11'(data_byte);
  assign szn      = cmd.size_wide ? szn_w : szn_n;
  assign new_last = last_acc - szn[15:0];
  assign emit_last = ({1'b0, idx} + 7'd1) == {1'b0, cnt};
  assign esz      = (cbr || emit_last) ? lsz[10:0] : mem_q;
  assign out_free = !out_valid || !out_stall;

  // status to the controller
  always_comb begin
    sts.plen_zero   = packet_length == 16'd0;
    sts.plen_big    = {1'b0, packet_length} > 17'(MAX_PACKET_BYTES);
    sts.plen_one    = packet_length == 16'd1;
    sts.plen_even   = !packet_length[0];
    sts.toc_code    = data_byte[1:0];
    sts.rem_zero    = rem == 16'd0;
    sts.remd_zero   = remd == 16'd0;
    sts.cnt_bad     = (cb == 6'd0) || ({1'b0, cb} > 7'(MAX_FRAMES)) ||
                      (dur > 18'(MAX_DURATION));
    sts.byte_pad    = data_byte[6];
    sts.byte_ff     = data_byte == PAD_CONT;
    sts.byte_esc    = data_byte >= SIZE_ESC;
    sts.pad_fail    = acc17 > {1'b0, remd};
    sts.cb_vbr      = data_byte[7];
    sts.cb_le1      = cb <= 6'd1;
    sts.fl_vbr      = flags[1];
    sts.cnt_le1     = cnt <= 6'd1;
    sts.rpad_zero   = r_pad == 16'd0;
    sts.size_fail_n = (16'(data_byte) > remd) || (11'(data_byte) > 11'(MAX_FRAME_BYTES)) ||
                      (szn_n > {1'b0, last_acc});
    sts.size_fail_w = (16'(sz_w) > remd) || (sz_w > 11'(MAX_FRAME_BYTES)) ||
                      (szn_w > {1'b0, last_acc});
    sts.size_done   = ({1'b0, sidx} + 7'd2) >= {1'b0, cnt};
    sts.lsz_big     = lsz > 16'(MAX_FRAME_BYTES);
    sts.div_done    = div_done;
    sts.div_rem_nz  = div_r != '0;
    sts.out_free    = out_free;
    sts.emit_last   = emit_last;
  end

  // header registers
  always_ff @(posedge clk) begin
    if (cmd.take_toc) begin
      toc      <= data_byte;
      rem      <= plen_m1;
      hdr      <= 16'd1;
      pad      <= '0;
      flags    <= (data_byte[1:0] == CODE_TWO) ? 2'b10 : 2'b00;
      sidx     <= '0;
      last_acc <= plen_m1;
      cbr      <= data_byte[1:0] != CODE_TWO;
      lsz      <= (data_byte[1:0] == CODE_EQUAL) ? {1'b0, plen_m1[15:1]} : plen_m1;
      case (data_byte[1:0])
        CODE_ONE: cnt <= 6'd1;
        CODE_ARB: cnt <= 6'd0;
        default:  cnt <= 6'd2;
      endcase
    end
    if (cmd.take_count) begin
      hdr      <= hdr + 16'd1;
      rem      <= remd;
      cnt      <= cb;
      flags    <= {data_byte[7], data_byte[6]};
      last_acc <= remd;
      lsz      <= remd;
      sidx     <= '0;
      cbr      <= !data_byte[7];
    end
    if (cmd.take_pad) begin
      hdr      <= hdr + 16'd1;
      pad      <= acc17[15:0];
      rem      <= (data_byte == PAD_CONT) ? remd : r_pad;
      last_acc <= r_pad;
      lsz      <= r_pad;
      sidx     <= '0;
      cbr      <= !flags[1];
    end
    if (cmd.take_low) begin
      hdr <= hdr + 16'd1;
      rem <= remd;
      low <= data_byte;
    end
    if (cmd.take_size) begin
      hdr      <= hdr + 16'd1;
      rem      <= remd;
      last_acc <= new_last;
      lsz      <= new_last;
      sidx     <= sidx + 6'd1;
      cbr      <= 1'b0;
    end
    if (cmd.div_load) begin
      lsz <= div_q;
    end
    if (cmd.emit_start) begin
      idx <= '0;
      off <= hdr;
    end
    if (cmd.emit_step) begin
      idx <= idx + 6'd1;
      off <= off + 16'(esz);
    end
  end

  // frame size memory
  always_ff @(posedge clk) begin
    if (cmd.take_size) begin
      mem[sidx[IW-1:0]] <= sz;
    end
    mem_q <= mem[idx[IW-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_fail || cmd.out_empty || cmd.emit_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_empty) begin
      status            <= ST_EMPTY;
      mode              <= '0;
      bandwidth         <= '0;
      stereo            <= 1'b0;
      samples_per_frame <= '0;
      frame_code        <= '0;
      frame_count       <= '0;
      frame_index       <= '0;
      frame_size        <= '0;
      frame_offset      <= '0;
      padding_bytes     <= '0;
      last              <= 1'b1;
    end else if (cmd.out_fail) begin
      status            <= ST_BAD;
      mode              <= ti.mode;
      bandwidth         <= ti.bw;
      stereo            <= toc[2];
      samples_per_frame <= ti.fs;
      frame_code        <= toc[1:0];
      frame_count       <= '0;
      frame_index       <= '0;
      frame_size        <= '0;
      frame_offset      <= '0;
      padding_bytes     <= '0;
      last              <= 1'b1;
    end else if (cmd.emit_step) begin
      status            <= ST_OK;
      mode              <= ti.mode;
      bandwidth         <= ti.bw;
      stereo            <= toc[2];
      samples_per_frame <= ti.fs;
      frame_code        <= toc[1:0];
      frame_count       <= cnt;
      frame_index       <= idx;
      frame_size        <= esz;
      frame_offset      <= off;
      padding_bytes     <= pad;
      last              <= emit_last;
    end
  end

endmodule

// ===== src/opus_packet_framing_parser.sv =====
// ----------------------------------------------------------------------------
// opus_packet_framing_parser
// Opus TOC and frame length parser producing one descriptor per frame.
// ----------------------------------------------------------------------------
// Packet bytes are taken one per cycle while the header is parsed and while
// payload bytes stream past. When the header is complete the input is stalled
// while results go out: an empty or malformed packet gives its single result
// once the output register is free; a valid packet passes the size check and
// then, for each descriptor, the registered read of the frame size memory
// feeding the output register. A code 3 packet with constant sizes first runs
// the restoring divider. Bytes with no first_byte mark outside a header are
// swallowed without result.
// ----------------------------------------------------------------------------
module opus_packet_framing_parser #(
  parameter int MAX_FRAMES       = opfp_pkg::DEF_MAX_FRAMES,
  parameter int MAX_FRAME_BYTES  = opfp_pkg::DEF_MAX_FRAME_BYTES,
  parameter int MAX_DURATION     = opfp_pkg::DEF_MAX_DURATION,
  parameter int MAX_PACKET_BYTES = opfp_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [15:0] packet_length,
  input  logic        first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  mode,
  output logic [2:0]  bandwidth,
  output logic        stereo,
  output logic [11:0] samples_per_frame,
  output logic [1:0]  frame_code,
  output logic [5:0]  frame_count,
  output logic [5:0]  frame_index,
  output logic [10:0] frame_size,
  output logic [15:0] frame_offset,
  output logic [15:0] padding_bytes,
  output logic        last
);
  import opfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  opfp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .first_byte (first_byte),
    .in_stall   (in_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  opfp_dp #(
    .MAX_FRAMES       (MAX_FRAMES),
    .MAX_FRAME_BYTES  (MAX_FRAME_BYTES),
    .MAX_DURATION     (MAX_DURATION),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .data_byte         (data_byte),
    .packet_length     (packet_length),
    .cmd               (cmd),
    .sts               (sts),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .status            (status),
    .mode              (mode),
    .bandwidth         (bandwidth),
    .stereo            (stereo),
    .samples_per_frame (samples_per_frame),
    .frame_code        (frame_code),
    .frame_count       (frame_count),
    .frame_index       (frame_index),
    .frame_size        (frame_size),
    .frame_offset      (frame_offset),
    .padding_bytes     (padding_bytes),
    .last              (last)
  );

  // error and empty results always close the packet
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("error result without last");

  // last marks exactly the final frame
  a_ok_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> last == ((frame_index + 6'd1) == frame_count))
    else $error("last flag disagrees with frame index");

  // no byte is taken while a result is being produced
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step || cmd.out_fail || cmd.out_empty |-> in_stall)
    else $error("input taken during result output");

  // a reserved status code never leaves
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_EMPTY || status == ST_BAD)
    else $error("bad status code");

endmodule
